// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/rmts_pkg.sv =====
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared constants and types of the rate-monotonic tick scheduler.
// ----------------------------------------------------------------------------
package rmts_pkg;

    localparam int TASK_COUNT = 4;
    localparam int SLOTS      = 4;
    localparam int SLOT_W     = 2;
    localparam int DATA_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET_BASE = CFG_IDX_W'(SLOTS);
    localparam logic [CFG_IDX_W-1:0] REG_END         = CFG_IDX_W'(2 * SLOTS);

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] period;
        logic [SLOT_W-1:0] idx;
    } chain_t;

endpackage

// ===== src/rmts_cell.sv =====
// ----------------------------------------------------------------------------
// rmts_cell
// One task slot: release countdown, remaining work, and a stage of the
// shortest-period priority chain.
// ----------------------------------------------------------------------------
module rmts_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick,
    input  logic                           restart,
    input  logic [rmts_pkg::SLOT_W-1:0]    cell_idx,
    input  logic [rmts_pkg::DATA_W-1:0]    period,
    input  logic [rmts_pkg::DATA_W-1:0]    budget,
    input  rmts_pkg::chain_t               chain_in,
    input  rmts_pkg::chain_t               winner,
    output rmts_pkg::chain_t               chain_out,
    output logic                           released,
    output logic                           granted
);
    import rmts_pkg::*;

    logic [DATA_W-1:0] countdown_reg, countdown_next;
    logic [DATA_W-1:0] work_reg, work_next;
    logic [DATA_W-1:0] cd_eff;
    logic [DATA_W-1:0] work_eff;
    logic              active;
    logic              candidate;

    assign active   = (period != '0);
    assign cd_eff   = restart ? '0 : countdown_reg;
    assign released = active && (cd_eff == '0);
    assign work_eff = released ? budget : (restart ? '0 : work_reg);
    assign candidate = active && (work_eff != '0);

    always_comb
    begin
        chain_out = chain_in;
        if (candidate && (!chain_in.found || period < chain_in.period))
        begin
            chain_out.found  = 1'b1;
            chain_out.period = period;
            chain_out.idx    = cell_idx;
        end
    end

    assign granted = winner.found && (winner.idx == cell_idx);

    always_comb
    begin
        if (!active)
        begin
            countdown_next = '0;
            work_next      = '0;
        end
        else
        begin
            countdown_next = released ? period - DATA_W'(1) : cd_eff - DATA_W'(1);
            work_next      = granted ? work_eff - DATA_W'(1) : work_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= '0;
            work_reg      <= '0;
        end
        else if (tick)
        begin
            countdown_reg <= countdown_next;
            work_reg      <= work_next;
        end
    end

endmodule

// ===== src/rate_monotonic_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler
// The result is registered from the tick transaction.
// Throughput: one tick per cycle unless an untaken result holds off
// s_tready; the priority chain through the task cells is combinational.
// Reset clears all period, budget, countdown and work registers; the first
// tick after reset or restart releases every enabled task.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rate_monotonic_tick_scheduler
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rmts_pkg::IN_TDATA_W-1:0]   s_tdata,   // [0] restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rmts_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [0] busy_res,
                                                         // [2:1] running_task,
                                                         // [6:3] released_mask
    input  logic                              cfg_we,
    input  logic [rmts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rmts_pkg::DATA_W-1:0]       cfg_data
);
    import rmts_pkg::*;

    logic [DATA_W-1:0]      period_reg [SLOTS];
    logic [DATA_W-1:0]      budget_reg [SLOTS];
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    chain_t                 chain [TASK_COUNT+1];
    logic [TASK_COUNT-1:0]  released;
    logic [TASK_COUNT-1:0]  grant;
    logic [SLOTS-1:0]       mask;
    logic [SLOT_W-1:0]      run_idx;
    logic                   tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                period_reg[i] <= '0;
                budget_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index < REG_BUDGET_BASE)
                period_reg[cfg_index[SLOT_W-1:0]] <= cfg_data;
            else if (cfg_index < REG_END)
                budget_reg[cfg_index[SLOT_W-1:0]] <= cfg_data;
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign tick     = s_tvalid && s_tready;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TASK_COUNT; g++)
        begin : g_cell
            rmts_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .tick     (tick),
                .restart  (s_tdata[0]),
                .cell_idx (SLOT_W'(g)),
                .period   (period_reg[g]),
                .budget   (budget_reg[g]),
                .chain_in (chain[g]),
                .winner   (chain[TASK_COUNT]),
                .chain_out(chain[g+1]),
                .released (released[g]),
                .granted  (grant[g])
            );
        end
    endgenerate

    assign mask    = SLOTS'(released);
    assign run_idx = chain[TASK_COUNT].found ? chain[TASK_COUNT].idx : '0;
    assign m_tdata_next = OUT_TDATA_W'({mask, run_idx, chain[TASK_COUNT].found});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (s_tready)
            m_tvalid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (tick)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_NXT(a_tick_gives_result, tick, m_tvalid)
    `ASSERT_IMP(a_idle_index_zero, m_tvalid && !m_tdata[0], m_tdata[2:1] == '0)
    `ASSERT_IMP(a_single_grant, tick, $onehot0(grant))

endmodule

// ===== sim/rate_monotonic_tick_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler_tb
// Streams scheduler ticks into the block and holds its own copy of the
// rate-monotonic schedule: countdowns, remaining work and the configured
// periods and budgets. Each tick transaction updates that copy and queues the
// expected run/release result, which is compared field by field with the
// block's output. Directed configurations cover zero budgets, period one,
// disabled and re-enabled tasks, ties, period changes mid-run and stray
// register writes; random configurations follow. Both sides idle at random
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rmts_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_TOP = '1;

    typedef struct packed {
        logic [SLOTS-1:0]  released;
        logic [SLOT_W-1:0] runner;
        logic              busy;
    } tick_result_t;

    class rm_schedule_board;
        logic [DATA_W-1:0] period    [SLOTS];
        logic [DATA_W-1:0] budget    [SLOTS];
        logic [DATA_W-1:0] countdown [SLOTS];
        logic [DATA_W-1:0] work_left [SLOTS];
        tick_result_t      expected_q [$];
        int unsigned       fault_count;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                period[i]    = '0;
                budget[i]    = '0;
                countdown[i] = '0;
                work_left[i] = '0;
            end
            fault_count = 0;
        endfunction

        function bit task_enabled(int i);
            return (i < TASK_COUNT) && (period[i] != '0);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            if (idx < REG_BUDGET_BASE)
                period[SLOT_W'(idx - REG_PERIOD_BASE)] = value;
            else if (idx < REG_END)
                budget[SLOT_W'(idx - REG_BUDGET_BASE)] = value;
        endfunction

        function void note_tick(logic restart);
            tick_result_t r;
            bit           found;
            int           pick;
            r     = '0;
            found = 1'b0;
            pick  = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (restart)
                begin
                    countdown[i] = '0;
                    work_left[i] = '0;
                end
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!task_enabled(i))
                begin
                    countdown[i] = '0;
                    work_left[i] = '0;
                end
                else if (countdown[i] == '0)
                begin
                    work_left[i]  = budget[i];
                    countdown[i]  = period[i] - 1'b1;
                    r.released[i] = 1'b1;
                end
                else
                    countdown[i] = countdown[i] - 1'b1;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                if (task_enabled(i) && work_left[i] != '0 &&
                    (!found || period[i] < period[pick]))
                begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            if (found)
                work_left[pick] = work_left[pick] - 1'b1;
            r.busy   = found;
            r.runner = found ? SLOT_W'(pick) : '0;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            tick_result_t got;
            tick_result_t want;
            got = tick_result_t'(data[$bits(tick_result_t)-1:0]);
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $realtime, got);
                fault_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.busy !== want.busy)
            begin
                $display("%0t: busy_res expected %0d actual %0d",
                         $realtime, want.busy, got.busy);
                fault_count++;
            end
            if (got.runner !== want.runner)
            begin
                $display("%0t: running_task expected %0d actual %0d",
                         $realtime, want.runner, got.runner);
                fault_count++;
            end
            if (got.released !== want.released)
            begin
                $display("%0t: released_mask expected %b actual %b",
                         $realtime, want.released, got.released);
                fault_count++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [0] restart
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [0] busy_res, [2:1] running_task,
                                       // [6:3] released_mask
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    logic [DATA_W-1:0] cfg_period [SLOTS];
    logic [DATA_W-1:0] cfg_budget [SLOTS];
    logic              calm;
    logic              hold_req;

    rm_schedule_board board;

    rate_monotonic_tick_scheduler u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_tick(s_tdata[0]);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
    end

    // receiver: random back-pressure, one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 9);
        end
    end

    task put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.write_reg(idx, value);
    endtask

    task apply_config(input bit stray);
        for (int i = 0; i < SLOTS; i++)
            put_reg(REG_PERIOD_BASE + CFG_IDX_W'(i), cfg_period[i]);
        for (int i = 0; i < SLOTS; i++)
            put_reg(REG_BUDGET_BASE + CFG_IDX_W'(i), cfg_budget[i]);
        if (stray)
        begin
            put_reg(REG_END, 16'hFFFF);
            put_reg(REG_TOP, DATA_W'($urandom));
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task send_tick(input logic restart);
        int gap;
        if (!calm && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(restart);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.outstanding() != 0);
        repeat (3) @(posedge clk);
    endtask

    task random_config();
        int r;
        for (int i = 0; i < SLOTS; i++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                cfg_period[i] = '0;
            else if (r < 14)
                cfg_period[i] = '1;
            else if (r < 22)
                cfg_period[i] = 16'd1;
            else
                cfg_period[i] = DATA_W'($urandom_range(2, 16));
            r = $urandom_range(99);
            if (r < 8)
                cfg_budget[i] = '0;
            else if (r < 14)
                cfg_budget[i] = '1;
            else
                cfg_budget[i] = DATA_W'($urandom_range(1, 6));
        end
    endtask

    task random_ticks(input int count);
        for (int n = 0; n < count; n++)
            send_tick($urandom_range(99) < 4);
    endtask

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // period one with no budget, tie on period three, task 3 disabled,
        // idle ticks, stray register writes
        cfg_period = '{16'd1, 16'd3, 16'd3, 16'd0};
        cfg_budget = '{16'd0, 16'd1, 16'd1, 16'd5};
        apply_config(1'b1);
        send_tick(1'b1);
        for (int n = 0; n < 7; n++)
            send_tick(1'b0);
        settle();

        // periods changed mid-run, task 2 disabled, task 3 re-enabled
        cfg_period = '{16'd2, 16'd5, 16'd0, 16'd1};
        cfg_budget = '{16'd1, 16'd3, 16'd0, 16'hFFFF};
        apply_config(1'b0);
        for (int n = 0; n < 8; n++)
            send_tick(n == 4);
        settle();

        // field extremes
        cfg_period = '{16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF};
        cfg_budget = '{16'hFFFF, 16'd0, 16'd1, 16'hFFFF};
        apply_config(1'b0);
        for (int n = 0; n < 6; n++)
            send_tick(n == 5);
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            random_config();
            apply_config($urandom_range(3) == 0);
            calm     <= (ph == 2);
            hold_req <= hold_req | (ph == 5);
            random_ticks(110);
            settle();
        end

        repeat (5) @(posedge clk);
        if (board.fault_count == 0 && board.outstanding() == 0)
            $display("rate_monotonic_tick_scheduler test passed");
        else
            $display("rate_monotonic_tick_scheduler test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("rate_monotonic_tick_scheduler test failed");
        $finish;
    end

endmodule
